[hdl/moving_average_filter_assert.svh]
// Assertion macros for the moving average filter checker.
// Depends on signals named clk and rst_n in the scope of each use.
`ifndef MOVING_AVERAGE_FILTER_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MAF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MAF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[hdl/mavg_pkg.sv]
// Shared types and constants of the moving average filter.
// Used by the interfaces, the divider, the top level and the checker.
package mavg_pkg;

  localparam int unsigned DEFAULT_DEPTH    = 64;
  localparam int unsigned DEFAULT_SAMPLE_W = 32;
  localparam int unsigned CFG_W            = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd64;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_READ,
    SEQ_ADD,
    SEQ_DIV_GO,
    SEQ_DIV_WAIT,
    SEQ_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_ABS,
    DIV_ITER,
    DIV_SIGN,
    DIV_SAT,
    DIV_DONE
  } div_state_t;

endpackage

[hdl/mavg_if.sv]
// Valid/ready channel interfaces for the sample and average beats.
// Depends on mavg_pkg for the opcode type and default width.
interface mavg_in_if #(
  parameter int unsigned SAMPLE_W = mavg_pkg::DEFAULT_SAMPLE_W
) ();
  logic                   valid;
  logic                   ready;
  mavg_pkg::opcode_t      opcode;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink (input valid, input opcode, input sample, output ready);
endinterface

interface mavg_out_if #(
  parameter int unsigned SAMPLE_W = mavg_pkg::DEFAULT_SAMPLE_W
) ();
  logic                   valid;
  logic                   ready;
  logic signed [SAMPLE_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

[hdl/mavg_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mavg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/mavg_divider.sv]
// Iterative signed divider: running sum by window length, two quotient bits
// per cycle, truncation toward zero and saturation to the sample range.
// Depends on mavg_pkg for the state type.
module mavg_divider #(
  parameter int unsigned SUM_W = 38,
  parameter int unsigned LEN_W = 7,
  parameter int unsigned OUT_W = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum,
  input  logic [LEN_W-1:0]        den,
  output logic                    done,
  output logic signed [OUT_W-1:0] quotient
);

  localparam int unsigned DIV_W = SUM_W + (SUM_W % 2);
  localparam int unsigned STEPS = DIV_W / 2;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);
  localparam int unsigned REM_W = LEN_W + 1;

  mavg_pkg::div_state_t state_r, state_nxt;

  logic [DIV_W-1:0] dvd_r;
  logic [LEN_W-1:0] den_r;
  logic [LEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic [DIV_W:0]   qs_r;
  logic [OUT_W-1:0] res_r;

  logic [REM_W-1:0] r1, r2, den_x;
  logic             q1, q2;
  logic [LEN_W-1:0] r1b, r2b;
  logic             in_range;

  assign den_x = {1'b0, den_r};
  assign r1    = {rem_r, dvd_r[DIV_W-1]};
  assign q1    = (r1 >= den_x);
  assign r1b   = q1 ? LEN_W'(r1 - den_x) : LEN_W'(r1);
  assign r2    = {r1b, dvd_r[DIV_W-2]};
  assign q2    = (r2 >= den_x);
  assign r2b   = q2 ? LEN_W'(r2 - den_x) : LEN_W'(r2);

  assign in_range = (&qs_r[DIV_W:OUT_W-1]) || (~|qs_r[DIV_W:OUT_W-1]);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mavg_pkg::DIV_IDLE: if (start) state_nxt = mavg_pkg::DIV_ABS;
      mavg_pkg::DIV_ABS:  state_nxt = mavg_pkg::DIV_ITER;
      mavg_pkg::DIV_ITER: if (cnt_r == '0) state_nxt = mavg_pkg::DIV_SIGN;
      mavg_pkg::DIV_SIGN: state_nxt = mavg_pkg::DIV_SAT;
      mavg_pkg::DIV_SAT:  state_nxt = mavg_pkg::DIV_DONE;
      mavg_pkg::DIV_DONE: state_nxt = mavg_pkg::DIV_IDLE;
      default:            state_nxt = mavg_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_r)
      mavg_pkg::DIV_DONE: done = 1'b1;
      default:            done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mavg_pkg::DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      mavg_pkg::DIV_IDLE: begin
        if (start) begin
          dvd_r <= DIV_W'(sum);
          neg_r <= sum[SUM_W-1];
          den_r <= den;
        end
      end
      mavg_pkg::DIV_ABS: begin
        if (neg_r) begin
          dvd_r <= -dvd_r;
        end
        rem_r <= '0;
        cnt_r <= CNT_W'(STEPS - 1);
      end
      mavg_pkg::DIV_ITER: begin
        dvd_r <= {dvd_r[DIV_W-3:0], q1, q2};
        rem_r <= r2b;
        cnt_r <= cnt_r - 1'b1;
      end
      mavg_pkg::DIV_SIGN: begin
        qs_r <= neg_r ? -{1'b0, dvd_r} : {1'b0, dvd_r};
      end
      mavg_pkg::DIV_SAT: begin
        if (in_range) begin
          res_r <= qs_r[OUT_W-1:0];
        end else if (qs_r[DIV_W]) begin
          res_r <= {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
          res_r <= {1'b0, {(OUT_W-1){1'b1}}};
        end
      end
      default: ;
    endcase
  end

  assign quotient = res_r;

endmodule

[hdl/moving_average_filter.sv]
// Top level of the moving average filter: sequencer, running sum, sample ring.
// Depends on mavg_pkg, mavg_if, mavg_ram and mavg_divider.
//
// Use: in_bus carries one beat per item, opcode plus a signed sample; a
// sample beat returns the average of the last window_length samples on
// out_bus, a clear beat empties the window and returns zero. cfg_we with
// cfg_wdata sets window_length (zero acts as one, values above the ring
// depth act as the depth); write it only while no beat is in flight.
// A sample beat passes through the read, add, divide-start and divide-wait states;
// it waits until the divider, which retires two quotient bits per cycle, reports
// done, and then its result moves to the output state. A clear beat goes straight
// to the output state with a zero result. One beat is processed at a time,
// and in_ready returns once the result is handed to the output register, so a new
// beat is accepted only after the result of the last one has been handed on.
// Reset empties the window, zeroes the sum and sets window_length to 64; the
// average ramps up over the first window.
// A stalled receiver holds the result in the output register; the next beat
// is still accepted and its result waits until that register is free.
module moving_average_filter #(
  parameter int unsigned BUFFER_DEPTH = mavg_pkg::DEFAULT_DEPTH,
  parameter int unsigned SAMPLE_WIDTH = mavg_pkg::DEFAULT_SAMPLE_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  mavg_in_if.sink                    in_bus,
  mavg_out_if.source                 out_bus,
  input  logic                       cfg_we,
  input  logic [mavg_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(BUFFER_DEPTH);
  localparam int unsigned LEN_W = IDX_W + 1;
  localparam int unsigned SUM_W = SAMPLE_WIDTH + IDX_W;

  mavg_pkg::seq_state_t state_r, state_nxt;

  logic [mavg_pkg::CFG_W-1:0]  window_r;
  logic [IDX_W-1:0]            idx_r;
  logic [LEN_W-1:0]            fill_r;
  logic signed [SUM_W-1:0]     sum_r;
  logic [SAMPLE_WIDTH-1:0]     sample_r;
  logic signed [SAMPLE_WIDTH-1:0] res_r;
  logic signed [SAMPLE_WIDTH-1:0] avg_r;
  logic                        out_valid_r;

  logic [31:0]             len32;
  logic [LEN_W-1:0]        len_eff;
  logic [LEN_W-1:0]        idx_inc;
  logic                    slot_valid;
  logic                    accept;
  logic                    in_ready;
  logic                    ram_re;
  logic                    ram_we;
  logic                    div_start;
  logic                    out_load;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;
  logic                    div_done;
  logic signed [SAMPLE_WIDTH-1:0] div_q;

  always_comb begin
    if (window_r == '0) begin
      len32 = 32'd1;
    end else if (32'(window_r) > BUFFER_DEPTH) begin
      len32 = 32'(BUFFER_DEPTH);
    end else begin
      len32 = 32'(window_r);
    end
  end

  assign len_eff    = len32[LEN_W-1:0];
  assign idx_inc    = {1'b0, idx_r} + 1'b1;
  assign slot_valid = ({1'b0, idx_r} < fill_r);
  assign accept     = in_bus.valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mavg_pkg::SEQ_IDLE: begin
        if (accept) begin
          state_nxt = (in_bus.opcode == mavg_pkg::OP_CLEAR) ? mavg_pkg::SEQ_OUT
                                                            : mavg_pkg::SEQ_READ;
        end
      end
      mavg_pkg::SEQ_READ:     state_nxt = mavg_pkg::SEQ_ADD;
      mavg_pkg::SEQ_ADD:      state_nxt = mavg_pkg::SEQ_DIV_GO;
      mavg_pkg::SEQ_DIV_GO:   state_nxt = mavg_pkg::SEQ_DIV_WAIT;
      mavg_pkg::SEQ_DIV_WAIT: if (div_done) state_nxt = mavg_pkg::SEQ_OUT;
      mavg_pkg::SEQ_OUT:      if (out_load) state_nxt = mavg_pkg::SEQ_IDLE;
      default:                state_nxt = mavg_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      mavg_pkg::SEQ_IDLE: begin
        in_ready = 1'b1;
        ram_re   = 1'b1;
      end
      mavg_pkg::SEQ_ADD:    ram_we    = 1'b1;
      mavg_pkg::SEQ_DIV_GO: div_start = 1'b1;
      mavg_pkg::SEQ_OUT:    out_load  = !out_valid_r || out_bus.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mavg_pkg::SEQ_IDLE;
      window_r    <= mavg_pkg::WINDOW_RESET;
      idx_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
      if (accept && (in_bus.opcode == mavg_pkg::OP_CLEAR)) begin
        idx_r  <= '0;
        fill_r <= '0;
        sum_r  <= '0;
      end
      if (state_r == mavg_pkg::SEQ_READ && slot_valid) begin
        sum_r <= sum_r - SUM_W'($signed(ram_rdata));
      end
      if (state_r == mavg_pkg::SEQ_ADD) begin
        sum_r <= sum_r + SUM_W'($signed(sample_r));
        idx_r <= (idx_inc >= len_eff) ? '0 : idx_inc[IDX_W-1:0];
        if (!slot_valid) begin
          fill_r <= idx_inc;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_bus.sample;
      res_r    <= '0;
    end
    if (state_r == mavg_pkg::SEQ_DIV_WAIT && div_done) begin
      res_r <= div_q;
    end
    if (out_load) begin
      avg_r <= res_r;
    end
  end

  mavg_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (BUFFER_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (sample_r),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  mavg_divider #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W),
    .OUT_W (SAMPLE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .sum      (sum_r),
    .den      (len_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_bus.ready    = in_ready;
  assign out_bus.valid   = out_valid_r;
  assign out_bus.average = avg_r;

endmodule

[hdl/mavg_checker.sv]
// Port-level checker for the moving average filter, bound to the top level.
// Depends on mavg_pkg and moving_average_filter_assert.svh.
`include "moving_average_filter_assert.svh"

module mavg_checker #(
  parameter int unsigned SAMPLE_W = mavg_pkg::DEFAULT_SAMPLE_W
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input mavg_pkg::opcode_t          in_opcode,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_average
);

  logic       in_beat;
  logic       out_beat;
  logic [1:0] pend_r;
  logic       last_clear_r;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r       <= '0;
      last_clear_r <= 1'b0;
    end else begin
      pend_r <= pend_r + {1'b0, in_beat} - {1'b0, out_beat};
      if (in_beat) begin
        last_clear_r <= (in_opcode == mavg_pkg::OP_CLEAR);
      end
    end
  end

  `MAF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_average))
  `MAF_ASSERT_NOW(a_out_has_item, out_valid, pend_r != 2'd0)
  `MAF_ASSERT_NOW(a_two_pending_stalls, pend_r == 2'd2, !in_ready)
  `MAF_ASSERT_NEXT(a_busy_after_beat, in_beat, !in_ready)
  `MAF_ASSERT_NOW(a_clear_gives_zero, out_beat && pend_r == 2'd1 && last_clear_r, out_average == '0)

endmodule

bind moving_average_filter mavg_checker #(
  .SAMPLE_W (SAMPLE_WIDTH)
) u_mavg_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .in_opcode   (in_bus.opcode),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_average (out_bus.average)
);
